FILE: src/heightmap_slope_stencil_core_macros.svh
// assertion helpers shared by the stencil core files
`ifndef HEIGHTMAP_SLOPE_STENCIL_CORE_MACROS_SVH
`define HEIGHTMAP_SLOPE_STENCIL_CORE_MACROS_SVH

// clocked property, masked while reset is applied
`define HSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define HSS_NEVER(lbl, cond, msg) \
	`HSS_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/hss_pkg.sv
`timescale 1ns / 1ps
package hss_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ROWS_MAX = 1024;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(ROWS_MAX) + 1;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int HGT_W = 16;
	localparam int SLOPE_W = 7;
	localparam int QBIT_W = $clog2(SLOPE_W);
	localparam int LANES = 8;
	localparam int LANE_W = $clog2(LANES);
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW = $clog2(JOBQ_DEPTH);
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int FRAC = 16;
	localparam int XY_W = 36;
	localparam int Z_W = 25;
	localparam int ANG_W = 23;
	localparam int SUM_W = 26;
	localparam int CNT_W = $clog2(LANES) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] GRID_WIDTH_RST = 11'd256;
	localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 11'd256;

	// run = 10 height units = 160 in 1/16 steps
	localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(160 << FRAC);
	localparam logic [ANG_W-1:0] ANG_MAX = ANG_W'(90 << FRAC);
	localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(90 << FRAC);

	typedef struct packed {
		logic opcode;
		logic [HGT_W-1:0] height_sample;
	} in_item_t;

	typedef struct packed {
		logic [SLOPE_W-1:0] slope_degrees;
		logic frame_last;
	} out_item_t;

	typedef struct packed {
		logic [LANES-1:0][HGT_W-1:0] diff;
		logic [LANES-1:0] mask;
		logic last;
	} job_t;

	typedef struct packed {
		logic [JOBQ_AW:0] level;
		logic nonempty;
	} jobq_status_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] a;
		case (i)
			4'd0: a = Z_W'(2949120);
			4'd1: a = Z_W'(1740967);
			4'd2: a = Z_W'(919879);
			4'd3: a = Z_W'(466945);
			4'd4: a = Z_W'(234379);
			4'd5: a = Z_W'(117304);
			4'd6: a = Z_W'(58666);
			4'd7: a = Z_W'(29335);
			4'd8: a = Z_W'(14668);
			4'd9: a = Z_W'(7334);
			4'd10: a = Z_W'(3667);
			4'd11: a = Z_W'(1833);
			4'd12: a = Z_W'(917);
			4'd13: a = Z_W'(458);
			4'd14: a = Z_W'(229);
			default: a = Z_W'(115);
		endcase
		return a;
	endfunction

	function automatic logic [HGT_W-1:0] abs_diff(input logic [HGT_W-1:0] a,
		input logic [HGT_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// arithmetic shift that truncates toward zero
	function automatic logic signed [XY_W-1:0] shift_tz(input logic signed [XY_W-1:0] v,
		input logic [STEP_W-1:0] s);
		logic signed [XY_W-1:0] m;
		m = -v;
		return v[XY_W-1] ? -(m >>> s) : (v >>> s);
	endfunction

endpackage

FILE: src/heightmap_slope_stencil_core.sv
`timescale 1ns / 1ps
// 3x3 slope filter over a height grid streamed in raster order.
// input side: drive item and push; the item is taken on a clock edge where
// full is low. opcode 0 carries a height sample, opcode 1 is a flush item.
// a frame is grid_width x grid_height samples followed by grid_width + 1
// flush items; the result for a cell becomes due grid_width + 1 items after
// its sample, and frame_last marks the final cell of the grid.
// result side: while empty is low, result holds the oldest slope; pop takes it.
// items that produce no result go through at one per cycle while full is low.
// each result passes the back end in order: 16 cordic steps over eight neighbor
// lanes, a sum of the lane angles and a restoring division; the back end works
// on one job at a time, and the job queue of four entries lets the front keep
// filling the line stores meanwhile. when pop stays low, the two-entry result
// queue and then the job queue fill up and full rises; nothing is dropped.
// reset (arst_n low) sets both grid sizes to 256 and starts a new frame;
// a configuration write also restarts the frame and is allowed only when idle;
// the block itself does not enforce this, so the user must keep to it.
module heightmap_slope_stencil_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hss_pkg::CFG_W-1:0] cfg_data,
	input logic push,
	input hss_pkg::in_item_t item,
	output logic full,
	output hss_pkg::out_item_t result,
	output logic empty,
	input logic pop
);
	import hss_pkg::*;

	job_t job_in, job_head;
	jobq_status_t jq;
	logic job_push, job_pop;

	hss_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.item(item),
		.full(full),
		.job_push(job_push),
		.job(job_in),
		.jq(jq)
	);

	hss_job_fifo u_jobq (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.din(job_in),
		.pop(job_pop),
		.head(job_head),
		.status(jq)
	);

	hss_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(job_head),
		.jq(jq),
		.job_pop(job_pop),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

endmodule

FILE: src/hss_front.sv
`timescale 1ns / 1ps
module hss_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hss_pkg::CFG_W-1:0] cfg_data,
	input logic push,
	input hss_pkg::in_item_t item,
	output logic full,
	output logic job_push,
	output hss_pkg::job_t job,
	input hss_pkg::jobq_status_t jq
);
	import hss_pkg::*;

	logic [CFG_W-1:0] width_q, height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0] w_eff, col_inc;
	logic [ROW_W-1:0] h_eff, r_cell;
	logic [COL_W-1:0] c_cell;
	logic acc, emit, last, top_ok, bot_ok, left_ok, right_ok;
	logic [LANES-1:0] mask;
	logic [HGT_W-1:0] sample;

	logic [HGT_W-1:0] upper_mem [MAX_WIDTH];
	logic [HGT_W-1:0] middle_mem [MAX_WIDTH];

	logic valid_s1, emit_s1, last_s1, fwd_s1;
	logic [LANES-1:0] mask_s1;
	logic [COL_W-1:0] col_s1;
	logic [HGT_W-1:0] v_s1, up_rd_s1, mid_rd_s1, fwd_up_s1, fwd_mid_s1;
	logic [HGT_W-1:0] up_eff, mid_eff;
	logic [HGT_W-1:0] win_q [3][3];
	logic [HGT_W-1:0] nb [LANES];

	assign full = (32'(jq.level) + 32'(valid_s1)) >= JOBQ_DEPTH;
	assign acc = push && !full;

	always_comb begin
		if (width_q == '0) begin
			w_eff = (COL_W+1)'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			w_eff = (COL_W+1)'(width_q);
		end
		if (height_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (int'(height_q) > ROWS_MAX) begin
			h_eff = ROW_W'(ROWS_MAX);
		end else begin
			h_eff = ROW_W'(height_q);
		end

		// a result exists once the cell one row and one column back is complete
		emit = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
		if (col_q == '0) begin
			r_cell = row_q - ROW_W'(2);
			c_cell = COL_W'(w_eff - (COL_W+1)'(1));
		end else begin
			r_cell = row_q - ROW_W'(1);
			c_cell = col_q - COL_W'(1);
		end
		top_ok = r_cell != '0;
		bot_ok = ({1'b0, r_cell} + (ROW_W+1)'(1)) < {1'b0, h_eff};
		left_ok = c_cell != '0;
		right_ok = ({1'b0, c_cell} + (COL_W+1)'(1)) < w_eff;
		last = (r_cell == h_eff - ROW_W'(1)) && ({1'b0, c_cell} == w_eff - (COL_W+1)'(1));
		mask = {bot_ok & right_ok, bot_ok, bot_ok & left_ok, right_ok, left_ok,
			top_ok & right_ok, top_ok, top_ok & left_ok};
		col_inc = {1'b0, col_q} + (COL_W+1)'(1);
		// flush items and drain rows feed zero
		sample = (!item.opcode && row_q < h_eff) ? item.height_sample : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= GRID_WIDTH_RST;
			height_q <= GRID_HEIGHT_RST;
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (cfg_write) begin
				case (cfg_index)
					REG_GRID_WIDTH: width_q <= cfg_data;
					REG_GRID_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (acc) begin
				if (emit && last) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end

	// same column written by the item ahead (one-cell rows) bypasses the store
	assign up_eff = fwd_s1 ? fwd_up_s1 : up_rd_s1;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			v_s1 <= sample;
			col_s1 <= col_q;
			emit_s1 <= emit;
			last_s1 <= last;
			mask_s1 <= mask;
			fwd_s1 <= valid_s1 && (col_s1 == col_q);
			fwd_up_s1 <= mid_eff;
			fwd_mid_s1 <= v_s1;
			up_rd_s1 <= upper_mem[col_q];
			mid_rd_s1 <= middle_mem[col_q];
		end
		if (valid_s1) begin
			upper_mem[col_s1] <= mid_eff;
			middle_mem[col_s1] <= v_s1;
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= up_eff;
			win_q[1][2] <= mid_eff;
			win_q[2][2] <= v_s1;
		end
	end

	// neighbors as the window stands after this shift; centre is win_q[1][2]
	always_comb begin
		nb[0] = win_q[0][1];
		nb[1] = win_q[0][2];
		nb[2] = up_eff;
		nb[3] = win_q[1][1];
		nb[4] = mid_eff;
		nb[5] = win_q[2][1];
		nb[6] = win_q[2][2];
		nb[7] = v_s1;
		for (int i = 0; i < LANES; i++) begin
			job.diff[i] = mask_s1[i] ? abs_diff(win_q[1][2], nb[i]) : '0;
		end
		job.mask = mask_s1;
		job.last = last_s1;
	end

	assign job_push = valid_s1 && emit_s1;

endmodule

FILE: src/hss_job_fifo.sv
`timescale 1ns / 1ps
module hss_job_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input hss_pkg::job_t din,
	input logic pop,
	output hss_pkg::job_t head,
	output hss_pkg::jobq_status_t status
);
	import hss_pkg::*;

	job_t mem_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_q, rd_q;
	logic [JOBQ_AW:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + JOBQ_AW'(1);
			if (pop) rd_q <= rd_q + JOBQ_AW'(1);
			level_q <= level_q + (JOBQ_AW+1)'(push) - (JOBQ_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	assign head = mem_q[rd_q];
	assign status.level = level_q;
	assign status.nonempty = level_q != '0;

endmodule

FILE: src/hss_back.sv
`timescale 1ns / 1ps
`include "heightmap_slope_stencil_core_macros.svh"
module hss_back (
	input logic clk,
	input logic arst_n,
	input hss_pkg::job_t job,
	input hss_pkg::jobq_status_t jq,
	output logic job_pop,
	output hss_pkg::out_item_t result,
	output logic empty,
	input logic pop
);
	import hss_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT = 3'd1;
	localparam logic [2:0] ST_ACC = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_PUT = 3'd4;

	logic [2:0] state_q;
	logic signed [XY_W-1:0] x_q [LANES];
	logic signed [XY_W-1:0] y_q [LANES];
	logic signed [XY_W-1:0] x_nx [LANES];
	logic signed [XY_W-1:0] y_nx [LANES];
	logic signed [XY_W-1:0] xs [LANES];
	logic signed [XY_W-1:0] ys [LANES];
	logic signed [Z_W-1:0] z_q [LANES];
	logic signed [Z_W-1:0] z_nx [LANES];
	logic [ANG_W-1:0] ang [LANES];
	logic [LANES-1:0] zero_q, mask_q;
	logic last_q;
	logic [STEP_W-1:0] step_q;
	logic [LANE_W-1:0] lane_q;
	logic [SUM_W-1:0] sum_q, den;
	logic [CNT_W-1:0] cnt_q;
	logic [SLOPE_W-1:0] quot_q;
	logic [QBIT_W-1:0] qbit_q;
	logic take;

	out_item_t oq_q [2];
	logic oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic oq_push, oq_pop;

	assign job_pop = (state_q == ST_IDLE) && jq.nonempty;
	assign oq_push = (state_q == ST_PUT) && (oq_cnt_q != 2'd2);
	assign oq_pop = pop && (oq_cnt_q != 2'd0);

	// one vectoring step per lane per cycle
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			xs[i] = shift_tz(x_q[i], step_q);
			ys[i] = shift_tz(y_q[i], step_q);
			if (!y_q[i][XY_W-1] && y_q[i] != '0) begin
				x_nx[i] = x_q[i] + ys[i];
				y_nx[i] = y_q[i] - xs[i];
				z_nx[i] = z_q[i] + atan_q16(step_q);
			end else begin
				x_nx[i] = x_q[i] - ys[i];
				y_nx[i] = y_q[i] + xs[i];
				z_nx[i] = z_q[i] - atan_q16(step_q);
			end
			if (!mask_q[i] || zero_q[i] || z_q[i][Z_W-1]) begin
				ang[i] = '0;
			end else if (z_q[i] > Z_MAX) begin
				ang[i] = ANG_MAX;
			end else begin
				ang[i] = z_q[i][ANG_W-1:0];
			end
		end
		den = (SUM_W'(cnt_q) << FRAC) << qbit_q;
		take = (cnt_q != '0) && (sum_q >= den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (jq.nonempty) state_q <= ST_ROT;
				ST_ROT: if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_q <= ST_ACC;
				ST_ACC: if (lane_q == LANE_W'(LANES - 1)) state_q <= ST_DIV;
				ST_DIV: if (qbit_q == '0) state_q <= ST_PUT;
				ST_PUT: if (oq_push) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < LANES; i++) begin
					x_q[i] <= CORDIC_X0;
					y_q[i] <= XY_W'({job.diff[i], FRAC'(0)});
					z_q[i] <= '0;
					zero_q[i] <= job.diff[i] == '0;
				end
				mask_q <= job.mask;
				last_q <= job.last;
				step_q <= '0;
			end
			ST_ROT: begin
				for (int i = 0; i < LANES; i++) begin
					x_q[i] <= x_nx[i];
					y_q[i] <= y_nx[i];
					z_q[i] <= z_nx[i];
				end
				step_q <= step_q + STEP_W'(1);
				sum_q <= '0;
				lane_q <= '0;
				cnt_q <= CNT_W'($countones(mask_q));
			end
			ST_ACC: begin
				sum_q <= sum_q + SUM_W'(ang[lane_q]);
				lane_q <= lane_q + LANE_W'(1);
				quot_q <= '0;
				qbit_q <= QBIT_W'(SLOPE_W - 1);
			end
			// restoring division by count << 16 gives the whole degrees directly
			ST_DIV: begin
				if (take) begin
					sum_q <= sum_q - den;
					quot_q[qbit_q] <= 1'b1;
				end
				qbit_q <= qbit_q - QBIT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= 1'b0;
			oq_rd_q <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) oq_wr_q <= ~oq_wr_q;
			if (oq_pop) oq_rd_q <= ~oq_rd_q;
			oq_cnt_q <= oq_cnt_q + 2'(oq_push) - 2'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q].slope_degrees <= quot_q;
			oq_q[oq_wr_q].frame_last <= last_q;
		end
	end

	assign result = oq_q[oq_rd_q];
	assign empty = oq_cnt_q == 2'd0;

	`HSS_NEVER(a_oq_overflow, oq_cnt_q > 2'd2, "result queue over capacity")
	`HSS_ASSERT(a_pop_when_idle, job_pop |-> state_q == ST_IDLE, "job taken while busy")
	`HSS_ASSERT(a_slope_range, oq_push |-> quot_q <= 7'd90, "slope above 90 degrees")

endmodule
